@@ rtl/hta_pkg.sv @@
`timescale 1ns / 1ps
package hta_pkg;

  localparam int SLOTS       = 256;
  localparam int SLOT_BITS   = 8;
  localparam int CNT_BITS    = SLOT_BITS + 1;
  localparam int HANDLE_BITS = 32;
  localparam int VALUE_BITS  = 32;
  localparam int LIMIT_BITS  = 32;

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_DEL = 2'd1;
  localparam logic [1:0] REQ_GET = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_NOREG = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } hta_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } hta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } hta_stat_t;

endpackage

@@ rtl/hta_ram.sv @@
`timescale 1ns / 1ps
module hta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/hta_ctrl.sv @@
`timescale 1ns / 1ps
module hta_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hta_pkg::hta_stat_t stat,
  output hta_pkg::hta_cmd_t  cmd
);
  import hta_pkg::*;

  hta_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // a request stays in execution while the result register is blocked
  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !stat.out_free) |=> (state_r == S_EXEC))
    else $error("execution left while result register was blocked");

endmodule

@@ rtl/hta_datapath.sv @@
`timescale 1ns / 1ps
module hta_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hta_pkg::hta_cmd_t              cmd,
  output hta_pkg::hta_stat_t             stat,
  input  logic                          cfg_valid,
  input  logic [hta_pkg::LIMIT_BITS-1:0] cfg_data,
  input  logic [1:0]                    in_req_type,
  input  logic [hta_pkg::HANDLE_BITS-1:0] in_handle_number,
  input  logic [hta_pkg::VALUE_BITS-1:0] in_user_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [hta_pkg::HANDLE_BITS-1:0] out_new_handle,
  output logic [hta_pkg::VALUE_BITS-1:0] out_found_value
);
  import hta_pkg::*;

  // request captured on accept
  logic [1:0]             req_r;
  logic [HANDLE_BITS-1:0] hnd_r;
  logic [VALUE_BITS-1:0]  val_r;

  logic [LIMIT_BITS-1:0]  limit_r, limit_nxt;
  logic [HANDLE_BITS-1:0] counter_r, counter_nxt;
  logic [SLOT_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [SLOT_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic                   wr_wrap_r, wr_wrap_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [SLOTS-1:0]       valid_r, valid_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] new_handle_r, new_handle_nxt;
  logic [VALUE_BITS-1:0]  found_r, found_nxt;

  logic [SLOT_BITS-1:0]   fifo_rdata;
  logic [HANDLE_BITS-1:0] hnd_rdata;
  logic [VALUE_BITS-1:0]  val_rdata;

  logic [SLOT_BITS-1:0]   add_slot;
  logic [SLOT_BITS-1:0]   ref_slot;
  logic [CNT_BITS-1:0]    step;
  logic [CNT_BITS-1:0]    step0;
  logic [HANDLE_BITS:0]   sum;
  logic                   wrap;
  logic [HANDLE_BITS-1:0] new_cnt;
  logic                   match;

  logic                   hnd_we, val_we, fifo_we;

  assign stat.out_free = !out_valid_r || out_ready;

  // fifo entries not yet written stand for their own index, taken from rd_ptr
  assign add_slot = (wr_wrap_r || (rd_ptr_r < wr_ptr_r)) ? fifo_rdata : rd_ptr_r;
  assign ref_slot = hnd_r[SLOT_BITS-1:0];

  assign step  = (add_slot == counter_r[SLOT_BITS-1:0]) ? CNT_BITS'(SLOTS)
               : {1'b0, SLOT_BITS'(add_slot - counter_r[SLOT_BITS-1:0])};
  assign step0 = (add_slot == '0) ? CNT_BITS'(SLOTS) : {1'b0, add_slot};
  assign sum   = {1'b0, counter_r} + (HANDLE_BITS + 1)'(step);
  assign wrap  = sum[HANDLE_BITS] || (sum[HANDLE_BITS-1:0] >= limit_r);
  assign new_cnt = wrap ? HANDLE_BITS'(step0) : sum[HANDLE_BITS-1:0];

  // an invalid slot never matches, and handle zero never matches
  assign match = (hnd_r != '0) && valid_r[ref_slot] && (hnd_rdata == hnd_r);

  always_comb begin
    limit_nxt      = cfg_valid ? cfg_data : limit_r;
    counter_nxt    = counter_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    wr_wrap_nxt    = wr_wrap_r;
    count_nxt      = count_r;
    valid_nxt      = valid_r;
    status_nxt     = status_r;
    new_handle_nxt = new_handle_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    hnd_we         = 1'b0;
    val_we         = 1'b0;
    fifo_we        = 1'b0;
    if (cmd.exec) begin
      out_valid_nxt  = 1'b1;
      status_nxt     = ST_NOREG;
      new_handle_nxt = '0;
      found_nxt      = '0;
      case (req_r)
        REQ_ADD: begin
          if (count_r == '0) begin
            status_nxt = ST_FULL;
          end else begin
            status_nxt          = ST_OK;
            new_handle_nxt      = new_cnt;
            counter_nxt         = new_cnt;
            hnd_we              = 1'b1;
            val_we              = 1'b1;
            valid_nxt[add_slot] = 1'b1;
            rd_ptr_nxt          = rd_ptr_r + 1'b1;
            count_nxt           = count_r - 1'b1;
          end
        end
        REQ_DEL: begin
          if (match) begin
            status_nxt          = ST_OK;
            valid_nxt[ref_slot] = 1'b0;
            if (count_r < CNT_BITS'(SLOTS)) begin
              fifo_we    = 1'b1;
              wr_ptr_nxt = wr_ptr_r + 1'b1;
              count_nxt  = count_r + 1'b1;
              if (wr_ptr_r == SLOT_BITS'(SLOTS - 1)) wr_wrap_nxt = 1'b1;
            end
          end
        end
        REQ_GET: begin
          if (match) begin
            status_nxt = ST_OK;
            found_nxt  = val_rdata;
          end
        end
        default: begin
          status_nxt = ST_NOREG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '1;
      counter_r   <= HANDLE_BITS'(1);
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      wr_wrap_r   <= 1'b0;
      count_r     <= CNT_BITS'(SLOTS);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      counter_r   <= counter_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      wr_wrap_r   <= wr_wrap_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      hnd_r <= in_handle_number;
      val_r <= in_user_value;
    end
    status_r     <= status_nxt;
    new_handle_r <= new_handle_nxt;
    found_r      <= found_nxt;
  end

  hta_ram #(.WIDTH(SLOT_BITS), .DEPTH(SLOTS)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wr_ptr_r),
    .wdata (ref_slot),
    .re    (cmd.capture),
    .raddr (rd_ptr_r),
    .rdata (fifo_rdata)
  );

  hta_ram #(.WIDTH(HANDLE_BITS), .DEPTH(SLOTS)) u_handle_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (add_slot),
    .wdata (new_cnt),
    .re    (cmd.capture),
    .raddr (in_handle_number[SLOT_BITS-1:0]),
    .rdata (hnd_rdata)
  );

  hta_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (add_slot),
    .wdata (val_r),
    .re    (cmd.capture),
    .raddr (in_handle_number[SLOT_BITS-1:0]),
    .rdata (val_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_new_handle  = new_handle_r;
  assign out_found_value = found_r;

  // free count tracks the pointer distance, full fifo showing as equal pointers
  a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[SLOT_BITS-1:0] == SLOT_BITS'(wr_ptr_r - rd_ptr_r))
    else $error("free count out of step with fifo pointers");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(SLOTS))
    else $error("free count above slot count");

  // an allocated handle is nonzero and lands in its own slot
  a_handle_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && req_r == REQ_ADD && count_r != '0)
      |-> (new_cnt != '0 && new_cnt[SLOT_BITS-1:0] == add_slot))
    else $error("allocated handle does not match its slot");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request left no result");

endmodule

@@ rtl/handle_table_allocator_top.sv @@
`timescale 1ns / 1ps
// handle table allocator: hands out nonzero handles whose low bits name a slot
// input channel: in_valid/in_ready with in_req_type (add, delete, look up),
//   in_handle_number and in_user_value; one result beat per request beat
// result channel: out_valid/out_ready with out_status, out_new_handle and
//   out_found_value, held in an output register until taken
// config channel: cfg_valid/cfg_ready with cfg_data sets the handle limit;
//   cfg_ready is always high, write only while no request is in flight
// timing: a request first does the registered read of the slot and free-list
//   memories, then the update; a new request is taken only once the last one
//   has left execution, and the result appears the cycle after the update
// stall: while the result register is full and not taken, a second request
//   is accepted and its update waits in execution until the register frees
// reset: all slots free, counter at one, free list in slot order, limit at
//   all ones; slot occupancy is flip-flop valid bits cleared at once, the
//   free list uses a fill mark, so no clearing pass is needed
module handle_table_allocator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hta_pkg::LIMIT_BITS-1:0]   cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_req_type,
  input  logic [hta_pkg::HANDLE_BITS-1:0]  in_handle_number,
  input  logic [hta_pkg::VALUE_BITS-1:0]   in_user_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [hta_pkg::HANDLE_BITS-1:0]  out_new_handle,
  output logic [hta_pkg::VALUE_BITS-1:0]   out_found_value
);
  import hta_pkg::*;

  hta_cmd_t  cmd;
  hta_stat_t stat;

  assign cfg_ready = 1'b1;

  hta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hta_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_handle_number (in_handle_number),
    .in_user_value    (in_user_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_new_handle   (out_new_handle),
    .out_found_value  (out_found_value)
  );

endmodule

@@ dv/tb_handle_table_allocator_top.sv @@
`timescale 1ns / 1ps
module tb_handle_table_allocator_top;
  import hta_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_ITEMS = 317;

  typedef struct packed {
    logic [1:0]             status;
    logic [HANDLE_BITS-1:0] new_handle;
    logic [VALUE_BITS-1:0]  found_value;
  } reply_t;

  typedef struct packed {
    logic [1:0]             req;
    logic [HANDLE_BITS-1:0] handle;
    logic [VALUE_BITS-1:0]  value;
    logic                   typed;
    reply_t                 want;
  } script_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [LIMIT_BITS-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_req_type;
  logic [HANDLE_BITS-1:0] in_handle_number;
  logic [VALUE_BITS-1:0]  in_user_value;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_status;
  logic [HANDLE_BITS-1:0] out_new_handle;
  logic [VALUE_BITS-1:0]  out_found_value;

  handle_table_allocator_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_handle_number (in_handle_number),
    .in_user_value    (in_user_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_new_handle   (out_new_handle),
    .out_found_value  (out_found_value)
  );

  // shadow copy of the table
  logic [HANDLE_BITS-1:0] tbl_handle [SLOTS];
  logic [VALUE_BITS-1:0]  tbl_value  [SLOTS];
  logic [SLOT_BITS-1:0]   free_ring  [SLOTS];
  logic [SLOT_BITS-1:0]   ring_rd;
  logic [SLOT_BITS-1:0]   ring_wr;
  int                     free_slots;
  logic [HANDLE_BITS-1:0] handle_ctr;
  logic [LIMIT_BITS-1:0]  limit_reg;

  reply_t pending [$];
  reply_t want_reply;
  int     errors;
  int     cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;
  bit     draining;
  int     full_hits;
  logic [HANDLE_BITS-1:0] last_freed;

  script_row_t script [22] = '{
    '{REQ_ADD,    32'hFFFF_FFFF, 32'hA5A5_0001, 1'b1, '{ST_OK, 32'd256, 32'd0}},
    '{REQ_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd257, 32'd0}},
    '{REQ_ADD,    32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_OK, 32'd258, 32'd0}},
    '{REQ_GET,    32'd256,       32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 32'hA5A5_0001}},
    '{REQ_GET,    32'd257,       32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 32'hFFFF_FFFF}},
    '{REQ_GET,    32'd258,       32'hFFFF_FFFF, 1'b1, '{ST_OK, 32'd0, 32'd0}},
    '{REQ_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_DEL,    32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_UNUSED, 32'd256,       32'hFFFF_FFFF, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_DEL,    32'd512,       32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_DEL,    32'd256,       32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 32'd0}},
    '{REQ_DEL,    32'd256,       32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_GET,    32'd256,       32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_GET,    32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_ADD,    32'h1234_5678, 32'h5A5A_5A5A, 1'b0, '0},
    '{REQ_GET,    32'd259,       32'h0000_0000, 1'b0, '0},
    '{REQ_DEL,    32'd257,       32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 32'd0}},
    '{REQ_ADD,    32'h0000_0000, 32'h8000_0001, 1'b0, '0},
    '{REQ_UNUSED, 32'h0000_0000, 32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_GET,    32'h8000_0000, 32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}},
    '{REQ_DEL,    32'd258,       32'h0000_0000, 1'b1, '{ST_OK, 32'd0, 32'd0}},
    '{REQ_GET,    32'd258,       32'h0000_0000, 1'b1, '{ST_NOREG, 32'd0, 32'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // distance 1..SLOTS from c to the next number in the slot's residue class
  function automatic logic [HANDLE_BITS:0] residue_gap(logic [HANDLE_BITS-1:0] c,
                                                       logic [SLOT_BITS-1:0] slot);
    logic [SLOT_BITS-1:0] d;
    logic [HANDLE_BITS:0] gap;
    d = slot - c[SLOT_BITS-1:0];
    gap = (HANDLE_BITS + 1)'(d);
    if (d == '0) gap = (HANDLE_BITS + 1)'(SLOTS);
    return gap;
  endfunction

  function automatic reply_t apply_request(logic [1:0] req, logic [HANDLE_BITS-1:0] h,
                                           logic [VALUE_BITS-1:0] v);
    reply_t               r;
    logic [SLOT_BITS-1:0] slot;
    logic [HANDLE_BITS:0] nxt;
    r = '{ST_NOREG, '0, '0};
    case (req)
      REQ_ADD: begin
        if (free_slots == 0) begin
          r.status = ST_FULL;
        end else begin
          slot = free_ring[ring_rd];
          ring_rd = ring_rd + 1'b1;
          free_slots--;
          nxt = {1'b0, handle_ctr} + residue_gap(handle_ctr, slot);
          // wrap to zero and take the fresh step once, whatever it lands on
          if (nxt[HANDLE_BITS] || nxt >= {1'b0, limit_reg}) nxt = residue_gap('0, slot);
          handle_ctr = nxt[HANDLE_BITS-1:0];
          tbl_handle[slot] = handle_ctr;
          tbl_value[slot] = v;
          r.status = ST_OK;
          r.new_handle = handle_ctr;
        end
      end
      REQ_DEL, REQ_GET: begin
        slot = h[SLOT_BITS-1:0];
        if (h != '0 && tbl_handle[slot] == h) begin
          r.status = ST_OK;
          if (req == REQ_DEL) begin
            tbl_handle[slot] = '0;
            tbl_value[slot] = '0;
            if (free_slots < SLOTS) begin
              free_ring[ring_wr] = slot;
              ring_wr = ring_wr + 1'b1;
              free_slots++;
            end
          end else begin
            r.found_value = tbl_value[slot];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_BITS-1:0] any_live_handle();
    int base;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++)
      if (tbl_handle[(base + k) % SLOTS] != '0) return tbl_handle[(base + k) % SLOTS];
    return '0;
  endfunction

  task automatic issue_request(logic [1:0] req, logic [HANDLE_BITS-1:0] h,
                               logic [VALUE_BITS-1:0] v, bit typed, reply_t typed_reply);
    reply_t guess;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_handle_number <= h;
    in_user_value <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    guess = apply_request(req, h, v);
    pending.push_back(typed ? typed_reply : guess);
  endtask

  // no write may land while a request is still in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_BITS-1:0] lim);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    limit_reg = lim;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("result beat with nothing pending: status %0d", out_status);
        errors++;
      end else begin
        want_reply = pending.pop_front();
        if (out_status !== want_reply.status) begin
          $error("status: expected %0d, got %0d", want_reply.status, out_status);
          errors++;
        end
        if (out_new_handle !== want_reply.new_handle) begin
          $error("new_handle: expected %0h, got %0h", want_reply.new_handle, out_new_handle);
          errors++;
        end
        if (out_found_value !== want_reply.found_value) begin
          $error("found_value: expected %0h, got %0h", want_reply.found_value,
                 out_found_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [1:0]             req;
    logic [HANDLE_BITS-1:0] h;
    logic [VALUE_BITS-1:0]  v;
    int                     roll;
    int                     phase_limit;

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_req_type = REQ_ADD;
    in_handle_number = '0;
    in_user_value = '0;
    errors = 0;
    cycle_count = 0;
    draining = 1'b0;
    full_hits = 0;
    last_freed = '0;
    send_idle_pct = 23;
    recv_idle_pct = 64;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_handle[i] = '0;
      tbl_value[i] = '0;
      free_ring[i] = SLOT_BITS'(i);
    end
    ring_rd = '0;
    ring_wr = '0;
    free_slots = SLOTS;
    handle_ctr = 1;
    limit_reg = '1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      issue_request(script[i].req, script[i].handle, script[i].value, script[i].typed,
                    script[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      settle();
      case (phase)
        0: begin
          phase_limit = SLOTS + 1;
        end
        1: begin
          phase_limit = $urandom_range(300, 70000);
          send_idle_pct = 64;
          recv_idle_pct = 23;
        end
        default: begin
          phase_limit = -1;
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_limit(LIMIT_BITS'(phase_limit));

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        req = REQ_ADD;
        h = $urandom();
        v = $urandom();
        // fill mode piles up adds until the table runs full, drain mode frees slots until at least 224 are free
        if (roll < (draining ? 10 : 85)) begin
          req = REQ_ADD;
        end else if (roll < (draining ? 65 : 88)) begin
          req = REQ_DEL;
          h = any_live_handle();
          last_freed = h;
        end else if (roll < (draining ? 85 : 95)) begin
          req = REQ_GET;
          h = any_live_handle();
        end else if (roll < (draining ? 93 : 97)) begin
          // stale handle, or right slot with the wrong generation
          req = $urandom_range(0, 1) ? REQ_DEL : REQ_GET;
          if ($urandom_range(0, 1))
            h = last_freed;
          else
            h = any_live_handle() + (HANDLE_BITS'($urandom_range(1, 255)) << SLOT_BITS);
        end else begin
          req = 2'($urandom_range(0, 3));
          if ($urandom_range(0, 7) == 0) h = '0;
        end
        issue_request(req, h, v, 1'b0, '0);

        if (!draining && free_slots == 0) full_hits++;
        if (full_hits >= 20) begin
          draining = 1'b1;
          full_hits = 0;
        end
        if (draining && free_slots >= 224) draining = 1'b0;
      end
    end

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
